// ----- hdl/ssst_pkg.sv -----
// ssst_pkg: shared types and codes for the sorted set span tracker
// no dependencies; used by the top level and its port checker

package ssst_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_VALID = 2'd0,
    STATUS_FEW   = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CountWidth  = 11;
  localparam int unsigned StatusWidth = 2;

endpackage

// ----- hdl/sorted_set_span_tracker.sv -----
// sorted_set_span_tracker: insertion-sorted value store with gap and range tracking
// depends on ssst_pkg; holds the sorted values in one synchronous memory
// a rejected item or the first value goes straight to the result; any other item reads the
//   top held value, moves each greater held value up one place, then writes into its slot
// one item at a time: items are accepted only when idle; a stalled result keeps the block busy
// reset: asynchronous active low; count, min/max, capacity and result valid clear; no span or memory clearing

module sorted_set_span_tracker #(
  parameter int unsigned MAX_COUNT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ssst_pkg::CountWidth-1:0]     cfg_capacity_i,
  // input item channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ssst_pkg::ValueWidth-1:0] value_i,
  // result item channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ssst_pkg::StatusWidth-1:0]    status_o,
  output logic [ssst_pkg::CountWidth-1:0]     count_o,
  output logic [ssst_pkg::ValueWidth-1:0]     shortest_span_o,
  output logic [ssst_pkg::ValueWidth-1:0]     longest_span_o
);

  import ssst_pkg::*;

  localparam int unsigned AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int unsigned CW = $clog2(MAX_COUNT + 1);
  localparam int unsigned LW = (CW > CountWidth) ? CW : CountWidth;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SHIFT  = 4'b0010,
    ST_PLACE  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // sorted value memory
  logic signed [ValueWidth-1:0] store_q [MAX_COUNT];
  logic signed [ValueWidth-1:0] rd_data_q;
  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic signed [ValueWidth-1:0] mem_wdata;

  // tracked statistics
  logic [CW-1:0]                held_q, held_d;
  logic [ValueWidth-1:0]        least_gap_q, least_gap_d;
  logic signed [ValueWidth-1:0] min_q, min_d, max_q, max_d;
  logic [CountWidth-1:0]        capacity_q;

  // per item working registers
  logic signed [ValueWidth-1:0] v_q, v_d;
  logic signed [ValueWidth-1:0] pred_q, pred_d, succ_q, succ_d;
  logic                         has_pred_q, has_pred_d, has_succ_q, has_succ_d;
  logic                         ins_q, ins_d;
  logic [AW-1:0]                idx_q, idx_d, idx_m1;

  // output register
  logic                         out_valid_q, out_valid_d;
  status_e                      status_q, status_d;
  logic [CountWidth-1:0]        count_q, count_d;
  logic [ValueWidth-1:0]        short_q, short_d, long_q, long_d;

  logic in_fire, rejected, greater, finish;

  // finish-time arithmetic
  logic [ValueWidth-1:0] gap_p, gap_s, gap_1, gap_2;
  logic [CW-1:0]         cnt_new;
  logic                  two_held, first;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  // store full against configured capacity and the memory depth
  assign rejected = (LW'(held_q) >= LW'(capacity_q)) || (LW'(held_q) >= LW'(MAX_COUNT));

  assign greater = rd_data_q > v_q;
  assign idx_m1  = idx_q - 1'b1;
  assign finish  = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // statistics update for the item being finished
  assign gap_p    = v_q - pred_q;
  assign gap_s    = succ_q - v_q;
  assign gap_1    = (has_pred_q && (gap_p < least_gap_q)) ? gap_p : least_gap_q;
  assign gap_2    = (has_succ_q && (gap_s < gap_1)) ? gap_s : gap_1;
  assign first    = (held_q == '0);
  assign cnt_new  = held_q + CW'(ins_q);
  assign two_held = (cnt_new >= CW'(2));

  // sequencer and memory port control
  always_comb begin
    state_d    = state_q;
    v_d        = v_q;
    pred_d     = pred_q;
    succ_d     = succ_q;
    has_pred_d = has_pred_q;
    has_succ_d = has_succ_q;
    ins_d      = ins_q;
    idx_d      = idx_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = v_q;
    mem_re     = 1'b0;
    mem_raddr  = idx_m1;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          v_d        = value_i;
          has_pred_d = 1'b0;
          has_succ_d = 1'b0;
          state_d    = ST_FINISH;
          if (rejected) begin
            ins_d = 1'b0;
          end else if (first) begin
            ins_d     = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = value_i;
          end else begin
            ins_d     = 1'b1;
            idx_d     = held_q[AW-1:0];
            mem_re    = 1'b1;
            mem_raddr = held_q[AW-1:0] - 1'b1;
            state_d   = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        if (greater) begin
          // move the larger entry up one place and look one lower
          mem_wdata  = rd_data_q;
          succ_d     = rd_data_q;
          has_succ_d = 1'b1;
          idx_d      = idx_m1;
          if (idx_m1 == '0) begin
            state_d = ST_PLACE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_m1 - 1'b1;
          end
        end else begin
          // slot found just above an entry not greater than the value
          mem_wdata  = v_q;
          pred_d     = rd_data_q;
          has_pred_d = 1'b1;
          state_d    = ST_FINISH;
        end
      end
      ST_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = v_q;
        has_pred_d = 1'b0;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // statistics and result formation
  always_comb begin
    held_d      = held_q;
    least_gap_d = least_gap_q;
    min_d       = min_q;
    max_d       = max_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    count_d     = count_q;
    short_d     = short_q;
    long_d      = long_q;
    if (finish) begin
      if (ins_q) begin
        held_d      = cnt_new;
        least_gap_d = gap_2;
        if (first || (v_q < min_q)) begin
          min_d = v_q;
        end
        if (first || (v_q > max_q)) begin
          max_d = v_q;
        end
      end
      out_valid_d = 1'b1;
      count_d     = CountWidth'(cnt_new);
      if (!ins_q) begin
        status_d = STATUS_FULL;
      end else if (!two_held) begin
        status_d = STATUS_FEW;
      end else begin
        status_d = STATUS_VALID;
      end
      short_d = two_held ? least_gap_d : '0;
      long_d  = two_held ? (max_d - min_d) : '0;
    end
  end

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= store_q[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      least_gap_q <= '1;
      min_q       <= '0;
      max_q       <= '0;
      capacity_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      least_gap_q <= least_gap_d;
      min_q       <= min_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_capacity_i;
      end
    end
  end

  // per item payload
  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    pred_q     <= pred_d;
    succ_q     <= succ_d;
    has_pred_q <= has_pred_d;
    has_succ_q <= has_succ_d;
    ins_q      <= ins_d;
    idx_q      <= idx_d;
    status_q   <= status_d;
    count_q    <= count_d;
    short_q    <= short_d;
    long_q     <= long_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign count_o         = count_q;
  assign shortest_span_o = short_q;
  assign longest_span_o  = long_q;

endmodule

// ----- hdl/ssst_checker.sv -----
// ssst_checker: port-level checks for the sorted set span tracker
// depends on ssst_pkg; bound to sorted_set_span_tracker below

module ssst_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  input  logic [ssst_pkg::StatusWidth-1:0]       status_o,
  input  logic [ssst_pkg::CountWidth-1:0]        count_o,
  input  logic [ssst_pkg::ValueWidth-1:0]        shortest_span_o,
  input  logic [ssst_pkg::ValueWidth-1:0]        longest_span_o
);

  import ssst_pkg::*;

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(count_o))
    else $error("result item changed while stalled");

  // no undefined status code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_VALID) || (status_o == STATUS_FEW) ||
                    (status_o == STATUS_FULL))
    else $error("bad status code");

  // smallest neighbour gap never exceeds the full range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_VALID) |-> shortest_span_o <= longest_span_o)
    else $error("shortest span above longest span");

  // with fewer than two values the spans read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FEW)
      |-> (count_o <= 11'd1) && (shortest_span_o == '0) && (longest_span_o == '0))
    else $error("spans reported with fewer than two values");

endmodule

bind sorted_set_span_tracker ssst_checker u_ssst_checker (.*);

// ----- tb/testbench.sv -----
// testbench: self-checking run for the sorted set span tracker
// depends on ssst_pkg and sorted_set_span_tracker; needs no files or arguments
// a mirror of the sorted store predicts each result item the directed table does not give, checked field by field

`timescale 1ns / 100ps

module testbench;
  import ssst_pkg::*;

  localparam int unsigned SetDepth   = 1024;
  localparam int unsigned StallLimit = 10000;
  localparam int unsigned DirRows    = 18;
  localparam int unsigned PhaseCount = 5;

  typedef struct packed {
    status_e               status;
    logic [CountWidth-1:0] count;
    logic [ValueWidth-1:0] shortest;
    logic [ValueWidth-1:0] longest;
  } span_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [ValueWidth-1:0] data;
    logic                  typed;
    status_e               status;
    logic [CountWidth-1:0] count;
    logic [ValueWidth-1:0] shortest;
    logic [ValueWidth-1:0] longest;
  } stim_row_t;

  // spread: uniform values; crowded: uniform values mixed with duplicates, neighbors and extremes
  typedef enum logic {MIX_SPREAD, MIX_CROWDED} value_mix_e;

  typedef struct packed {
    logic [CountWidth-1:0] capacity;
    int unsigned           send_pct;
    int unsigned           recv_pct;
    int unsigned           items;
    value_mix_e            mix;
    int unsigned           hold;
  } phase_t;

  // directed rows: rejects at capacity zero, first values, lowered capacity
  localparam stim_row_t DirTable [DirRows] = '{
    '{ROW_ITEM, 32'h0000_0000, 1'b1, STATUS_FULL,  11'd0, 32'h0,         32'h0},
    '{ROW_ITEM, 32'h8000_0000, 1'b1, STATUS_FULL,  11'd0, 32'h0,         32'h0},
    '{ROW_ITEM, 32'h7fff_ffff, 1'b1, STATUS_FULL,  11'd0, 32'h0,         32'h0},
    '{ROW_CFG,  32'd0,         1'b0, STATUS_VALID, 11'd0, 32'h0,         32'h0},
    '{ROW_ITEM, 32'hffff_ffff, 1'b1, STATUS_FULL,  11'd0, 32'h0,         32'h0},
    '{ROW_CFG,  32'd1,         1'b0, STATUS_VALID, 11'd0, 32'h0,         32'h0},
    '{ROW_ITEM, 32'h8000_0000, 1'b1, STATUS_FEW,   11'd1, 32'h0,         32'h0},
    '{ROW_ITEM, 32'h7fff_ffff, 1'b1, STATUS_FULL,  11'd1, 32'h0,         32'h0},
    '{ROW_ITEM, 32'h8000_0000, 1'b1, STATUS_FULL,  11'd1, 32'h0,         32'h0},
    '{ROW_CFG,  32'd6,         1'b0, STATUS_VALID, 11'd0, 32'h0,         32'h0},
    '{ROW_ITEM, 32'h0000_0000, 1'b1, STATUS_VALID, 11'd2, 32'h8000_0000, 32'h8000_0000},
    '{ROW_ITEM, 32'h4000_0000, 1'b0, STATUS_VALID, 11'd0, 32'h0,         32'h0},
    '{ROW_ITEM, 32'hc000_0000, 1'b0, STATUS_VALID, 11'd0, 32'h0,         32'h0},
    '{ROW_ITEM, 32'h2000_0000, 1'b0, STATUS_VALID, 11'd0, 32'h0,         32'h0},
    '{ROW_CFG,  32'd4,         1'b0, STATUS_VALID, 11'd0, 32'h0,         32'h0},
    '{ROW_ITEM, 32'h1000_0000, 1'b0, STATUS_VALID, 11'd0, 32'h0,         32'h0},
    '{ROW_ITEM, 32'h5555_5555, 1'b0, STATUS_VALID, 11'd0, 32'h0,         32'h0},
    '{ROW_ITEM, 32'haaaa_aaaa, 1'b0, STATUS_VALID, 11'd0, 32'h0,         32'h0}
  };

  // random phases: capacity, idling, item count, value mix, receiver hold-off
  localparam phase_t Phases [PhaseCount] = '{
    '{11'd120,  32, 59, 140, MIX_SPREAD,  0},
    '{11'd60,   32, 59, 20,  MIX_SPREAD,  0},
    '{11'd220,  59, 32, 130, MIX_SPREAD,  0},
    '{11'd2047, 0,  0,  80,  MIX_CROWDED, 400},
    '{11'd1024, 0,  0,  190, MIX_CROWDED, 0}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [CountWidth-1:0]        cfg_capacity_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [ValueWidth-1:0] value_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [StatusWidth-1:0]       status_o;
  logic [CountWidth-1:0]        count_o;
  logic [ValueWidth-1:0]        shortest_span_o;
  logic [ValueWidth-1:0]        longest_span_o;

  // mirror of the block state
  logic signed [ValueWidth-1:0] mirror_values [SetDepth];
  int unsigned                  mirror_count    = 0;
  logic [ValueWidth-1:0]        mirror_gap      = '1;
  logic signed [ValueWidth-1:0] mirror_lo       = '0;
  logic signed [ValueWidth-1:0] mirror_hi       = '0;
  logic [CountWidth-1:0]        mirror_capacity = '0;

  span_result_t pending_spans [$];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  send_idle_pct  = 32;
  int unsigned  recv_idle_pct  = 59;
  int unsigned  hold_request   = 0;

  sorted_set_span_tracker #(
    .MAX_COUNT(SetDepth)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .count_o        (count_o),
    .shortest_span_o(shortest_span_o),
    .longest_span_o (longest_span_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // insert into the mirror and work out the result item
  function automatic span_result_t predict_spans(input logic signed [ValueWidth-1:0] v);
    int unsigned           limit;
    int unsigned           pos;
    int                    k;
    logic [ValueWidth-1:0] g;
    span_result_t          r;
    limit = (mirror_capacity > SetDepth) ? SetDepth : mirror_capacity;
    if (mirror_count >= limit) begin
      r.status = STATUS_FULL;
    end else begin
      pos = 0;
      while (pos < mirror_count && mirror_values[pos] <= v) pos++;
      for (k = mirror_count; k > pos; k--) mirror_values[k] = mirror_values[k-1];
      mirror_values[pos] = v;
      // only the two new neighbor gaps can lower the least gap
      if (pos > 0) begin
        g = v - mirror_values[pos-1];
        if (g < mirror_gap) mirror_gap = g;
      end
      if (pos < mirror_count) begin
        g = mirror_values[pos+1] - v;
        if (g < mirror_gap) mirror_gap = g;
      end
      if (mirror_count == 0 || v < mirror_lo) mirror_lo = v;
      if (mirror_count == 0 || v > mirror_hi) mirror_hi = v;
      mirror_count++;
      r.status = (mirror_count < 2) ? STATUS_FEW : STATUS_VALID;
    end
    r.count = mirror_count[CountWidth-1:0];
    if (mirror_count >= 2) begin
      r.shortest = mirror_gap;
      r.longest  = mirror_hi - mirror_lo;
    end else begin
      r.shortest = '0;
      r.longest  = '0;
    end
    return r;
  endfunction

  // random value, crowded mix aims at held values and the extremes
  function automatic logic [ValueWidth-1:0] draw_value(input value_mix_e mix);
    int unsigned           pick;
    logic [ValueWidth-1:0] base;
    pick = $urandom_range(99);
    if (mix == MIX_SPREAD || mirror_count == 0 || pick < 40) return $urandom;
    base = mirror_values[$urandom_range(mirror_count - 1)];
    if (pick < 60) return base;
    if (pick < 75) return ($urandom_range(1) != 0) ? base + 1 : base - 1;
    case (pick % 4)
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // offer one item; on accept queue its expected result
  task automatic offer_value(input logic signed [ValueWidth-1:0] v, input logic typed,
                             input span_result_t want);
    span_result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    got = predict_spans(v);
    pending_spans.insert(pending_spans.size(), typed ? want : got);
  endtask

  // stop offering and wait until every result item has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CountWidth-1:0] cap);
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= cap;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i     <= 1'b0;
    mirror_capacity  = cap;
  endtask

  // result sink with random stalls and an occasional long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // compare each accepted result item with the oldest expectation
  always @(negedge clk_i) begin : result_check
    span_result_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected result item: status %0d count %0d", status_o, count_o);
        mismatch_count++;
      end else begin
        due = pending_spans.pop_front();
        if (status_o !== due.status) begin
          $error("status: expected %0d, actual %0d", due.status, status_o);
          mismatch_count++;
        end
        if (count_o !== due.count) begin
          $error("count: expected %0d, actual %0d", due.count, count_o);
          mismatch_count++;
        end
        if (shortest_span_o !== due.shortest) begin
          $error("shortest_span: expected %0h, actual %0h", due.shortest, shortest_span_o);
          mismatch_count++;
        end
        if (longest_span_o !== due.longest) begin
          $error("longest_span: expected %0h, actual %0h", due.longest, longest_span_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus: reset, directed table, random phases, drain
  initial begin : stimulus
    stim_row_t    row;
    phase_t       ph;
    span_result_t want;
    int           r;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    value_i        <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_capacity_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < DirRows; r++) begin
      row = DirTable[r];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        write_capacity(row.data[CountWidth-1:0]);
      end else begin
        want.status   = row.status;
        want.count    = row.count;
        want.shortest = row.shortest;
        want.longest  = row.longest;
        offer_value(row.data, row.typed, want);
      end
    end

    for (r = 0; r < PhaseCount; r++) begin
      ph = Phases[r];
      wait_drained();
      write_capacity(ph.capacity);
      send_idle_pct = ph.send_pct;
      recv_idle_pct = ph.recv_pct;
      hold_request  = ph.hold;
      repeat (ph.items) offer_value(draw_value(ph.mix), 1'b0, '0);
    end

    // drain, then leave room for any stray result item
    wait_drained();
    repeat (SetDepth + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
